@@ hdl/mhjs_pkg.sv @@
`timescale 1ns / 1ps

package mhjs_pkg;

   localparam int VAL_W         = 31;
   localparam int DEPTH_DEFAULT = 1024;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_SET    = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [VAL_W-1:0] id;
      logic [VAL_W-1:0] time_v;
      logic [VAL_W-1:0] total;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // executed time plus increment, clamped at the largest value
   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[VAL_W]) begin
         return {VAL_W{1'b1}};
      end
      return sum[VAL_W-1:0];
   endfunction

endpackage

@@ hdl/mhjs_ram.sv @@
`timescale 1ns / 1ps

module mhjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/min_heap_job_scheduler.sv @@
`timescale 1ns / 1ps

// channel | direction | ports                                              | handshake
// req     | in        | req_cmd, req_job_id, req_key_time, req_job_total   | req_valid / req_ready
// rsp     | out       | rsp_status, rsp_top_id, rsp_top_time, rsp_top_total,| rsp_valid / rsp_ready
//         |           | rsp_entry_count                                    |
//
// one command at a time, each heap level a read, compare and write on the ram's read and write ports:
// insert climbs from the new leaf towards the root, add and set sift the root entry down, remove
// first loads the last entry into the root and then sifts it down, and dropped and empty commands
// go straight to the response; DEPTH defaults to 1024 entries.
// reset clears the count and the control state only; the ram needs no clearing pass.
// the result sits in an output register, so a stalled rsp side holds only the final step.

module min_heap_job_scheduler #(
   parameter int DEPTH = mhjs_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [mhjs_pkg::VAL_W-1:0]          req_job_id,
   input  logic [mhjs_pkg::VAL_W-1:0]          req_key_time,
   input  logic [mhjs_pkg::VAL_W-1:0]          req_job_total,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [mhjs_pkg::VAL_W-1:0]          rsp_top_id,
   output logic [mhjs_pkg::VAL_W-1:0]          rsp_top_time,
   output logic [mhjs_pkg::VAL_W-1:0]          rsp_top_total,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_entry_count
);

   import mhjs_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_UP_RD  = 8'b0000_0010,
      S_UP_CMP = 8'b0000_0100,
      S_RM_LD  = 8'b0000_1000,
      S_DN_L   = 8'b0001_0000,
      S_DN_R   = 8'b0010_0000,
      S_DN_CMP = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   entry_type         cur_ff, cur_in;
   entry_type         left_ff, left_in;
   logic              has_r_ff, has_r_in;
   entry_type         top_ff, top_in;
   entry_type         res_ff, res_in;
   status_type        status_ff, status_in;
   logic              use_top_ff, use_top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              wr_en;
   logic [CNT_W-1:0]  wr_idx;
   logic [CNT_W-1:0]  wr_idx_m1;
   entry_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   logic [CNT_W:0]    left_idx;
   logic [CNT_W:0]    right_idx;
   logic [CNT_W:0]    left_m1;
   logic [CNT_W:0]    count_ext;
   logic [CNT_W-1:0]  parent_idx;
   logic [CNT_W-1:0]  parent_m1;
   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  count_p1;
   logic              pick_r;
   entry_type         child;
   logic [CNT_W:0]    child_idx;
   logic              do_swap;
   logic              accept;

   assign accept     = req_valid && req_ready;
   assign left_idx   = {idx_ff, 1'b0};
   assign right_idx  = {idx_ff, 1'b1};
   assign left_m1    = left_idx - 1'b1;
   assign count_ext  = {1'b0, count_ff};
   assign parent_idx = idx_ff >> 1;
   assign parent_m1  = parent_idx - 1'b1;
   assign count_m1   = count_ff - 1'b1;
   assign count_p1   = count_ff + 1'b1;
   assign wr_idx_m1  = wr_idx - 1'b1;

   // left child wins when strictly earlier than the right one or when there is no right child
   assign pick_r    = has_r_ff && !(left_ff.time_v < rd_data.time_v);
   assign child     = pick_r ? rd_data : left_ff;
   assign child_idx = pick_r ? right_idx : left_idx;
   assign do_swap   = (child.time_v < cur_ff.time_v) ||
                      ((child.time_v == cur_ff.time_v) && (cur_ff.id > child.id));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      has_r_in      = has_r_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      use_top_in    = use_top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_data       = cur_ff;
      rd_en         = 1'b0;
      rd_addr       = left_m1[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in  = ST_OK;
               use_top_in = 1'b1;
               idx_in     = CNT_W'(1);
               if (req_cmd == CMD_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_p1;
                     idx_in   = count_p1;
                     cur_in   = '{id: req_job_id, time_v: req_key_time,
                                  total: req_job_total};
                     state_in = S_UP_RD;
                  end
               end else if (count_ff == '0) begin
                  status_in  = ST_EMPTY;
                  use_top_in = 1'b0;
                  res_in     = '0;
                  state_in   = S_DONE;
               end else if (req_cmd == CMD_REMOVE) begin
                  use_top_in = 1'b0;
                  res_in     = top_ff;
                  rd_en      = 1'b1;
                  rd_addr    = count_m1[ADDR_W-1:0];
                  state_in   = S_RM_LD;
               end else begin
                  cur_in = top_ff;
                  if (req_cmd == CMD_ADD) begin
                     cur_in.time_v = sat_add(top_ff.time_v, req_key_time);
                  end else begin
                     cur_in.time_v = req_key_time;
                  end
                  state_in = S_DN_L;
               end
            end
         end
         S_UP_RD: begin
            if (idx_ff == CNT_W'(1)) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_m1[ADDR_W-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cur_ff.time_v < rd_data.time_v) begin
               // parent moves down into the hole
               wr_data  = rd_data;
               idx_in   = parent_idx;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RM_LD: begin
            cur_in   = rd_data;
            count_in = count_m1;
            state_in = S_DN_L;
         end
         S_DN_L: begin
            if (left_idx > count_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_m1[ADDR_W-1:0];
               state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            left_in  = rd_data;
            has_r_in = right_idx <= count_ext;
            rd_en    = right_idx <= count_ext;
            rd_addr  = left_idx[ADDR_W-1:0];
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (do_swap) begin
               wr_data  = child;
               idx_in   = child_idx[CNT_W-1:0];
               state_in = S_DN_L;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_entry_in  = use_top_ff ? top_ff : res_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // root copy kept in flops so results need no extra read
      top_in = (wr_en && (wr_idx == CNT_W'(1))) ? wr_data : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      has_r_ff      <= has_r_in;
      top_ff        <= top_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      use_top_ff    <= use_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   mhjs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_m1[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_id      = rsp_entry_ff.id;
   assign rsp_top_time    = rsp_entry_ff.time_v;
   assign rsp_top_total   = rsp_entry_ff.total;
   assign rsp_entry_count = rsp_count_ff;

endmodule
